// ===== hw/rtl/isbc_pkg.sv =====
// Shared types, constants and helpers for the IMU scale, bias and calibration block.
`timescale 1ns / 1ps
package isbc_pkg;

  localparam int unsigned RAW_W     = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned DIV_W     = 48;
  localparam int unsigned DIV_STEPS = DIV_W;
  localparam int unsigned NUM_LANES = 6;

  localparam int unsigned MAX_CAL_SAMPLES_DEF = 65535;

  localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 32'd20084;
  localparam logic [SCALE_W-1:0] GYRO_SCALE_RST  = 32'd1023001;

  localparam logic signed [DATA_W-1:0] GRAVITY_Q16     = 32'sd642689;
  localparam logic signed [DATA_W-1:0] TEMP_OFFSET_Q16 = 32'sd1376256;
  localparam logic [23:0]              TEMP_MUL        = 24'd6553600;
  localparam logic [CNT_W-1:0]         TEMP_DIV        = 16'd33387;
  localparam logic [CNT_W-1:0]         TEMP_HALF       = TEMP_DIV >> 1;
  localparam logic [7:0]               TEMP_WHOLE      = 8'(TEMP_MUL / 24'(TEMP_DIV));
  localparam logic [CNT_W-1:0]         TEMP_FRAC       = CNT_W'(TEMP_MUL % 24'(TEMP_DIV));
  localparam int unsigned              TEMP_RECIP_SH   = 45;
  localparam logic [29:0]              TEMP_RECIP      =
    30'((64'd1 << TEMP_RECIP_SH) / 64'(TEMP_DIV));

  localparam logic [65:0] GRAV_LO = 66'd49 << 32;
  localparam logic [65:0] GRAV_HI = 66'd169 << 32;

  typedef enum logic [1:0] {
    OP_MEASURE = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_FINISH  = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_MEASURED = 2'd0,
    ST_READ_ERR = 2'd1,
    ST_CAL_OK   = 2'd2,
    ST_CAL_KEPT = 2'd3
  } status_t;

  typedef enum logic {
    CFG_ACCEL_SCALE = 1'b0,
    CFG_GYRO_SCALE  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_DONE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic sample;
    logic finish;
  } lane_ctrl_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 64'sd2147483647) r = 32'sh7fffffff;
    else if (v < -64'sd2147483648) r = 32'sh80000000;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

// ===== hw/rtl/imu_scale_bias_calibrate_core.sv =====
// Top level of the IMU scale, bias and calibration block.
//
// Input channel (in_valid / in_stall) carries one raw six-axis frame plus
// temperature, an op code and a read status. Op 0 measures and gives one
// result word; op 1 adds a good frame to the calibration sums and gives none;
// op 2 finishes calibration and gives one word holding the biases in force;
// op 3 is dropped. Result words leave on out_valid / out_stall.
// The output register is loaded after the set-up cycle (S_PREP), 48 steps of
// the serial mean dividers in the axis lanes (S_DIV, one quotient bit a cycle;
// the temperature and gravity paths settle within these steps), the commit
// cycle (S_DONE) and the output cycle (S_OUT). The input stays stalled until
// the block is back in S_IDLE, so it takes no new frame while one is in work;
// ops 1 and 3 return to S_IDLE from S_DONE without an output cycle.
// While the receiver stalls, the result is held in the output register and
// the block finishes the next word, then waits for the register to drain.
// Synchronous reset clears biases, sums, the sample count and the handshake,
// and restores the default scale factors. Configuration (cfg_we, cfg_index,
// cfg_wdata) must be written while idle only; the block does not check.
`timescale 1ns / 1ps
module imu_scale_bias_calibrate_core #(
  parameter int unsigned MAX_CAL_SAMPLES = isbc_pkg::MAX_CAL_SAMPLES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic        in_read_ok,
  input  logic signed [15:0] in_accel_raw_x,
  input  logic signed [15:0] in_accel_raw_y,
  input  logic signed [15:0] in_accel_raw_z,
  input  logic signed [15:0] in_gyro_raw_x,
  input  logic signed [15:0] in_gyro_raw_y,
  input  logic signed [15:0] in_gyro_raw_z,
  input  logic signed [15:0] in_temp_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic signed [31:0] out_accel_x,
  output logic signed [31:0] out_accel_y,
  output logic signed [31:0] out_accel_z,
  output logic signed [31:0] out_gyro_x,
  output logic signed [31:0] out_gyro_y,
  output logic signed [31:0] out_gyro_z,
  output logic signed [31:0] out_temperature,
  output logic        out_gravity_ok
);

  localparam int unsigned CNT_STEP_W = $clog2(isbc_pkg::DIV_STEPS);
  localparam logic [CNT_STEP_W-1:0] LAST_STEP = CNT_STEP_W'(isbc_pkg::DIV_STEPS - 1);

  isbc_pkg::state_t state_r, state_nxt;
  isbc_pkg::lane_ctrl_t ctrl;
  logic [CNT_STEP_W-1:0] step_r, step_nxt;
  logic [31:0] accel_scale_r, gyro_scale_r;
  logic [isbc_pkg::CNT_W-1:0] count_r;
  isbc_pkg::op_t op_r;
  logic ok_r, cal_ok_r;
  logic in_acc, out_free, load_out;

  logic signed [15:0] raw [isbc_pkg::NUM_LANES];
  logic signed [31:0] corr [isbc_pkg::NUM_LANES];
  logic signed [31:0] bias [isbc_pkg::NUM_LANES];
  logic signed [31:0] temp_val;
  logic grav;

  logic out_valid_r;
  isbc_pkg::status_t status_r;
  logic signed [31:0] res_r [isbc_pkg::NUM_LANES];
  logic signed [31:0] temp_r;
  logic grav_r;

  assign raw[0] = in_accel_raw_x;
  assign raw[1] = in_accel_raw_y;
  assign raw[2] = in_accel_raw_z;
  assign raw[3] = in_gyro_raw_x;
  assign raw[4] = in_gyro_raw_y;
  assign raw[5] = in_gyro_raw_z;

  assign in_stall = state_r != isbc_pkg::S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctrl      = '0;
    load_out  = 1'b0;
    case (state_r)
      isbc_pkg::S_IDLE: begin
        if (in_acc) begin
          ctrl.load = 1'b1;
          state_nxt = isbc_pkg::S_PREP;
        end
      end
      isbc_pkg::S_PREP: begin
        ctrl.start = 1'b1;
        step_nxt   = '0;
        state_nxt  = isbc_pkg::S_DIV;
      end
      isbc_pkg::S_DIV: begin
        ctrl.step = 1'b1;
        step_nxt  = step_r + 1'b1;
        if (step_r == LAST_STEP) state_nxt = isbc_pkg::S_DONE;
      end
      isbc_pkg::S_DONE: begin
        ctrl.sample = (op_r == isbc_pkg::OP_SAMPLE) && ok_r &&
                      (32'(count_r) < MAX_CAL_SAMPLES);
        ctrl.finish = op_r == isbc_pkg::OP_FINISH;
        if (op_r == isbc_pkg::OP_MEASURE || op_r == isbc_pkg::OP_FINISH)
          state_nxt = isbc_pkg::S_OUT;
        else
          state_nxt = isbc_pkg::S_IDLE;
      end
      isbc_pkg::S_OUT: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = isbc_pkg::S_IDLE;
        end
      end
      default: state_nxt = isbc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= isbc_pkg::S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_scale_r <= isbc_pkg::ACCEL_SCALE_RST;
      gyro_scale_r  <= isbc_pkg::GYRO_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        isbc_pkg::CFG_ACCEL_SCALE: accel_scale_r <= cfg_wdata;
        isbc_pkg::CFG_GYRO_SCALE:  gyro_scale_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ctrl.finish) begin
      count_r <= '0;
    end else if (ctrl.sample) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r <= isbc_pkg::op_t'(in_op);
      ok_r <= in_read_ok;
    end
    if (ctrl.finish) cal_ok_r <= count_r != '0;
  end

  for (genvar i = 0; i < isbc_pkg::NUM_LANES; i++) begin : g_lane
    isbc_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .raw       (raw[i]),
      .scale     (i < 3 ? accel_scale_r : gyro_scale_r),
      .count     (count_r),
      .offset    (i == 2 ? isbc_pkg::GRAVITY_Q16 : 32'sd0),
      .corrected (corr[i]),
      .bias      (bias[i])
    );
  end

  isbc_merge u_merge (
    .clk         (clk),
    .ctrl        (ctrl),
    .ax          (corr[0]),
    .ay          (corr[1]),
    .az          (corr[2]),
    .temp_count  (in_temp_count),
    .temperature (temp_val),
    .gravity_ok  (grav)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load_out) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (op_r == isbc_pkg::OP_FINISH) begin
        status_r <= cal_ok_r ? isbc_pkg::ST_CAL_OK : isbc_pkg::ST_CAL_KEPT;
        for (int i = 0; i < isbc_pkg::NUM_LANES; i++) res_r[i] <= bias[i];
        temp_r <= '0;
        grav_r <= 1'b0;
      end else if (ok_r) begin
        status_r <= isbc_pkg::ST_MEASURED;
        for (int i = 0; i < isbc_pkg::NUM_LANES; i++) res_r[i] <= corr[i];
        temp_r <= temp_val;
        grav_r <= grav;
      end else begin
        status_r <= isbc_pkg::ST_READ_ERR;
        for (int i = 0; i < isbc_pkg::NUM_LANES; i++) res_r[i] <= '0;
        temp_r <= '0;
        grav_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_accel_x     = res_r[0];
  assign out_accel_y     = res_r[1];
  assign out_accel_z     = res_r[2];
  assign out_gyro_x      = res_r[3];
  assign out_gyro_y      = res_r[4];
  assign out_gyro_z      = res_r[5];
  assign out_temperature = temp_r;
  assign out_gravity_ok  = grav_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= MAX_CAL_SAMPLES)
    else $error("sample count above limit");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r ##1 out_valid_r |-> $past(state_r == isbc_pkg::S_OUT))
    else $error("result word loaded outside output cycle");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == isbc_pkg::S_DIV && step_r == LAST_STEP) |=> state_r == isbc_pkg::S_DONE)
    else $error("divider sequence length wrong");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.load |-> state_r == isbc_pkg::S_IDLE)
    else $error("capture while busy");

endmodule

// ===== hw/rtl/isbc_sdiv.sv =====
// Restoring serial divider, one quotient bit per step.
`timescale 1ns / 1ps
module isbc_sdiv (
  input  logic                         clk,
  input  logic                         start,
  input  logic                         step,
  input  logic [isbc_pkg::DIV_W-1:0]   dividend,
  input  logic [isbc_pkg::CNT_W-1:0]   divisor,
  output logic [isbc_pkg::DIV_W-1:0]   quotient
);

  logic [isbc_pkg::DIV_W-1:0] mag_r, mag_nxt;
  logic [isbc_pkg::CNT_W-1:0] rem_r, rem_nxt;
  logic [isbc_pkg::CNT_W:0]   rem_sh;
  logic                       qbit;

  always_comb begin
    rem_sh  = {rem_r, mag_r[isbc_pkg::DIV_W-1]};
    qbit    = rem_sh >= {1'b0, divisor};
    rem_nxt = qbit ? rem_sh[isbc_pkg::CNT_W-1:0] - divisor : rem_sh[isbc_pkg::CNT_W-1:0];
    mag_nxt = {mag_r[isbc_pkg::DIV_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= dividend;
      rem_r <= '0;
    end else if (step) begin
      mag_r <= mag_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = mag_r;

endmodule

// ===== hw/rtl/isbc_lane.sv =====
// One axis lane: scaling, bias correction, accumulation and mean for calibration.
`timescale 1ns / 1ps
module isbc_lane (
  input  logic                              clk,
  input  logic                              rst_n,
  input  isbc_pkg::lane_ctrl_t              ctrl,
  input  logic signed [isbc_pkg::RAW_W-1:0] raw,
  input  logic [isbc_pkg::SCALE_W-1:0]      scale,
  input  logic [isbc_pkg::CNT_W-1:0]        count,
  input  logic signed [isbc_pkg::DATA_W-1:0] offset,
  output logic signed [isbc_pkg::DATA_W-1:0] corrected,
  output logic signed [isbc_pkg::DATA_W-1:0] bias
);

  logic signed [48:0] prod, rnd;
  logic signed [40:0] shr;
  logic signed [isbc_pkg::DATA_W-1:0] scaled_r;
  logic signed [isbc_pkg::DATA_W-1:0] bias_r, bias_nxt;
  logic signed [isbc_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [isbc_pkg::DATA_W:0]   diff;
  logic [isbc_pkg::SUM_W-1:0]         sum_mag;
  logic [isbc_pkg::DIV_W-1:0]         dividend, quot;
  logic                               neg_r;
  logic signed [49:0]                 mean;

  always_comb begin
    prod = $signed(raw) * $signed({1'b0, scale});
    rnd  = prod + 49'sd128;
    shr  = rnd[48:8];
    diff = {scaled_r[isbc_pkg::DATA_W-1], scaled_r} - {bias_r[isbc_pkg::DATA_W-1], bias_r};
    corrected = isbc_pkg::sat32(64'(diff));
    sum_mag  = sum_r[isbc_pkg::SUM_W-1] ? isbc_pkg::SUM_W'(-sum_r) : isbc_pkg::SUM_W'(sum_r);
    dividend = sum_mag + isbc_pkg::DIV_W'(count >> 1);
    mean     = neg_r ? -$signed({2'b00, quot}) : $signed({2'b00, quot});
    mean     = mean - 50'(offset);
    bias_nxt = isbc_pkg::sat32(64'(mean));
    sum_nxt  = sum_r + isbc_pkg::SUM_W'(scaled_r);
  end

  isbc_sdiv u_div (
    .clk      (clk),
    .start    (ctrl.start),
    .step     (ctrl.step),
    .dividend (dividend),
    .divisor  (count),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load) scaled_r <= isbc_pkg::sat32(64'(shr));
    if (ctrl.start) neg_r <= sum_r[isbc_pkg::SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
      sum_r  <= '0;
    end else if (ctrl.finish) begin
      if (count != '0) bias_r <= bias_nxt;
      sum_r <= '0;
    end else if (ctrl.sample) begin
      sum_r <= sum_nxt;
    end
  end

  assign bias = bias_r;

endmodule

// ===== hw/rtl/isbc_merge.sv =====
// Merge stage: gravity window check over the accel lanes and temperature conversion.
`timescale 1ns / 1ps
module isbc_merge (
  input  logic                               clk,
  input  isbc_pkg::lane_ctrl_t               ctrl,
  input  logic signed [isbc_pkg::DATA_W-1:0] ax,
  input  logic signed [isbc_pkg::DATA_W-1:0] ay,
  input  logic signed [isbc_pkg::DATA_W-1:0] az,
  input  logic signed [isbc_pkg::RAW_W-1:0]  temp_count,
  output logic signed [isbc_pkg::DATA_W-1:0] temperature,
  output logic                               gravity_ok
);

  logic [isbc_pkg::RAW_W-1:0] tmag_r;
  logic                       tneg_r;
  logic [28:0]  tfrac_r;
  logic [58:0]  tprod_r;
  logic [13:0]  qest;
  logic [28:0]  qback, trem;
  logic [22:0]  tq_r;
  logic signed [23:0] tsgn;
  logic [31:0]  mx, my, mz;
  logic [63:0]  sqx_r, sqy_r, sqz_r;
  logic [65:0]  sq_sum;
  logic         grav_r;

  always_comb begin
    qest  = 14'(tprod_r >> isbc_pkg::TEMP_RECIP_SH);
    qback = 29'(qest) * 29'(isbc_pkg::TEMP_DIV);
    trem  = tfrac_r - qback;
    mx = ax[31] ? 32'(-ax) : 32'(ax);
    my = ay[31] ? 32'(-ay) : 32'(ay);
    mz = az[31] ? 32'(-az) : 32'(az);
    sq_sum = 66'(sqx_r) + 66'(sqy_r) + 66'(sqz_r);
    tsgn = tneg_r ? -$signed({1'b0, tq_r}) : $signed({1'b0, tq_r});
    temperature = 32'(tsgn) + isbc_pkg::TEMP_OFFSET_Q16;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      tmag_r <= temp_count[isbc_pkg::RAW_W-1] ? isbc_pkg::RAW_W'(-temp_count)
                                               : isbc_pkg::RAW_W'(temp_count);
      tneg_r <= temp_count[isbc_pkg::RAW_W-1];
    end
    if (ctrl.start)
      tfrac_r <= 29'(tmag_r) * 29'(isbc_pkg::TEMP_FRAC) + 29'(isbc_pkg::TEMP_HALF);
    if (ctrl.step) begin
      tprod_r <= 59'(tfrac_r) * 59'(isbc_pkg::TEMP_RECIP);
      tq_r    <= 23'(tmag_r) * 23'(isbc_pkg::TEMP_WHOLE) + 23'(qest) +
                 23'(trem >= 29'(isbc_pkg::TEMP_DIV));
      sqx_r  <= mx * mx;
      sqy_r  <= my * my;
      sqz_r  <= mz * mz;
      grav_r <= (sq_sum > isbc_pkg::GRAV_LO) && (sq_sum < isbc_pkg::GRAV_HI);
    end
  end

  assign gravity_ok = grav_r;

endmodule

// ===== test/tb_imu_scale_bias_calibrate_core.sv =====
// Self-checking testbench for the IMU scale, bias and calibration core.
`timescale 1ns / 1ps
module tb_imu_scale_bias_calibrate_core;

  typedef struct packed {
    isbc_pkg::op_t    op;
    logic             ok;
    logic [6:0][15:0] raw;
  } frame_t;

  typedef struct packed {
    isbc_pkg::status_t status;
    logic [5:0][31:0]  axis;
    logic [31:0]       temp;
    logic              grav;
  } reading_t;

  typedef struct {
    frame_t   f;
    bit       typed;
    reading_t r;
  } row_t;

  logic clk, rst_n;
  logic cfg_we;
  isbc_pkg::cfg_idx_t cfg_index;
  logic [31:0] cfg_wdata;
  logic in_valid, in_stall, in_read_ok;
  logic [1:0] in_op;
  logic signed [15:0] in_ax, in_ay, in_az, in_gx, in_gy, in_gz, in_t;
  logic out_valid, out_stall, out_gravity_ok;
  logic [1:0] out_status;
  logic signed [31:0] out_ax, out_ay, out_az, out_gx, out_gy, out_gz, out_temp;

  imu_scale_bias_calibrate_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_read_ok(in_read_ok),
    .in_accel_raw_x(in_ax), .in_accel_raw_y(in_ay), .in_accel_raw_z(in_az),
    .in_gyro_raw_x(in_gx), .in_gyro_raw_y(in_gy), .in_gyro_raw_z(in_gz),
    .in_temp_count(in_t),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_accel_x(out_ax), .out_accel_y(out_ay), .out_accel_z(out_az),
    .out_gyro_x(out_gx), .out_gyro_y(out_gy), .out_gyro_z(out_gz),
    .out_temperature(out_temp), .out_gravity_ok(out_gravity_ok)
  );

  longint unsigned accel_scale_m, gyro_scale_m;
  longint bias_m[6];
  longint sum_m[6];
  int unsigned good_m;

  reading_t expected_q[$];
  int errors, n_items, n_words, n_cal, n_grav;
  int send_idle, recv_idle;
  bit pressure_go, pressed;
  int hold_cnt;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint div_nearest(input longint n, input longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint unsigned square_abs(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : longint'(v);
    return m * m;
  endfunction

  function automatic bit calibrate_predict(input frame_t f, output reading_t r);
    longint sc[6];
    longint p, mean;
    longint unsigned sq;
    r = '0;
    for (int i = 0; i < 6; i++) begin
      p = longint'($signed(f.raw[i])) * longint'(i < 3 ? accel_scale_m : gyro_scale_m);
      sc[i] = clip32((p + 128) >>> 8);
    end
    case (f.op)
      isbc_pkg::OP_NONE: return 0;
      isbc_pkg::OP_SAMPLE: begin
        if (f.ok && good_m < isbc_pkg::MAX_CAL_SAMPLES_DEF) begin
          for (int i = 0; i < 6; i++) sum_m[i] += sc[i];
          good_m++;
        end
        return 0;
      end
      isbc_pkg::OP_MEASURE: begin
        if (f.ok) begin
          r.status = isbc_pkg::ST_MEASURED;
          for (int i = 0; i < 6; i++) r.axis[i] = 32'(clip32(sc[i] - bias_m[i]));
          r.temp = 32'(clip32(div_nearest(longint'($signed(f.raw[6])) * 6553600, 33387)
                              + 1376256));
          sq = square_abs($signed(r.axis[0])) + square_abs($signed(r.axis[1]))
               + square_abs($signed(r.axis[2]));
          r.grav = (sq > (64'd49 << 32)) && (sq < (64'd169 << 32));
        end else begin
          r.status = isbc_pkg::ST_READ_ERR;
        end
        return 1;
      end
      default: begin
        if (good_m > 0) begin
          r.status = isbc_pkg::ST_CAL_OK;
          for (int i = 0; i < 6; i++) begin
            mean = div_nearest(sum_m[i], longint'(good_m));
            if (i == 2) mean -= 642689;
            bias_m[i] = clip32(mean);
          end
        end else begin
          r.status = isbc_pkg::ST_CAL_KEPT;
        end
        for (int i = 0; i < 6; i++) begin
          r.axis[i] = 32'(bias_m[i]);
          sum_m[i] = 0;
        end
        good_m = 0;
        return 1;
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (pressure_go) begin
      hold_cnt = 500;
      pressure_go = 0;
    end
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else out_stall <= ($urandom_range(99) < recv_idle);
  end

  task automatic cmp_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $display("%0t: mismatch %s expected %0d actual %0d", $time, name, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reading_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected word status %0d", $time, out_status);
        errors++;
      end else begin
        e = expected_q.pop_front();
        n_words++;
        cmp_field("status", e.status, out_status);
        cmp_field("accel_x", $signed(e.axis[0]), out_ax);
        cmp_field("accel_y", $signed(e.axis[1]), out_ay);
        cmp_field("accel_z", $signed(e.axis[2]), out_az);
        cmp_field("gyro_x", $signed(e.axis[3]), out_gx);
        cmp_field("gyro_y", $signed(e.axis[4]), out_gy);
        cmp_field("gyro_z", $signed(e.axis[5]), out_gz);
        cmp_field("temperature", $signed(e.temp), out_temp);
        cmp_field("gravity_ok", e.grav, out_gravity_ok);
        if (e.status == isbc_pkg::ST_CAL_OK) n_cal++;
        if (e.grav) n_grav++;
      end
    end
  end

  task automatic send_frame(input frame_t f, input bit typed, input reading_t tr);
    reading_t r;
    bit taken;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= f.op;
    in_read_ok <= f.ok;
    in_ax <= f.raw[0]; in_ay <= f.raw[1]; in_az <= f.raw[2];
    in_gx <= f.raw[3]; in_gy <= f.raw[4]; in_gz <= f.raw[5];
    in_t <= f.raw[6];
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    n_items++;
    if (calibrate_predict(f, r)) expected_q.push_back(typed ? tr : r);
  endtask

  task automatic write_reg(input isbc_pkg::cfg_idx_t idx, input logic [31:0] val);
    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == isbc_pkg::CFG_ACCEL_SCALE) accel_scale_m = val;
    else gyro_scale_m = val;
  endtask

  function automatic logic [15:0] pick_raw();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: case ($urandom_range(3))
           0: return 16'h7fff;
           1: return 16'h8000;
           2: return 16'h0000;
           default: return 16'hffff;
         endcase
      default: return 16'($urandom_range(4000)) - 16'd2000;
    endcase
  endfunction

  function automatic frame_t level_frame(input isbc_pkg::op_t op, input logic ok);
    frame_t f;
    f.op = op;
    f.ok = ok;
    f.raw[0] = 16'($urandom_range(1600)) - 16'd800;
    f.raw[1] = 16'($urandom_range(1600)) - 16'd800;
    f.raw[2] = 16'd8192 + 16'($urandom_range(3000)) - 16'd1500;
    for (int i = 3; i < 6; i++) f.raw[i] = 16'($urandom_range(200)) - 16'd100;
    f.raw[6] = 16'($urandom);
    return f;
  endfunction

  row_t rows[$];
  frame_t fr;
  reading_t tr, none_r;
  int nburst;

  initial begin
    rst_n = 0; cfg_we = 0; cfg_index = isbc_pkg::CFG_ACCEL_SCALE; cfg_wdata = '0;
    in_valid = 0; in_op = isbc_pkg::OP_MEASURE; in_read_ok = 0;
    in_ax = 0; in_ay = 0; in_az = 0; in_gx = 0; in_gy = 0; in_gz = 0; in_t = 0;
    out_stall = 0; pressure_go = 0; pressed = 0; hold_cnt = 0;
    errors = 0; n_items = 0; n_words = 0; n_cal = 0; n_grav = 0;
    send_idle = 18; recv_idle = 73;
    accel_scale_m = 20084; gyro_scale_m = 1023001; good_m = 0;
    for (int i = 0; i < 6; i++) begin bias_m[i] = 0; sum_m[i] = 0; end
    none_r = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tr = '0; tr.status = isbc_pkg::ST_READ_ERR;
    rows.push_back('{'{isbc_pkg::OP_MEASURE, 1'b0, {7{16'h7fff}}}, 1'b1, tr});
    tr = '0; tr.status = isbc_pkg::ST_CAL_KEPT;
    rows.push_back('{'{isbc_pkg::OP_FINISH, 1'b1, {7{16'h0000}}}, 1'b1, tr});
    tr = '0; tr.status = isbc_pkg::ST_MEASURED; tr.temp = 32'd1376256;
    rows.push_back('{'{isbc_pkg::OP_MEASURE, 1'b1, {7{16'h0000}}}, 1'b1, tr});
    rows.push_back('{'{isbc_pkg::OP_MEASURE, 1'b1, {7{16'h7fff}}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_MEASURE, 1'b1, {7{16'h8000}}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_NONE, 1'b1, {7{16'h1234}}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_SAMPLE, 1'b0, {7{16'h7fff}}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_SAMPLE, 1'b1, {16'd0, 16'd50, 16'h8000, 16'd100,
                                                  16'hff00, 16'h7fff, 16'd0}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_SAMPLE, 1'b1, {16'd0, 16'd51, 16'h8001, 16'd90,
                                                  16'hff01, 16'h0000, 16'd0}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_FINISH, 1'b0, {7{16'h0000}}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_MEASURE, 1'b1, {16'h8000, 16'd0, 16'd8192, 16'd0,
                                                   16'd0, 16'h7fff, 16'h8000}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_FINISH, 1'b1, {7{16'h5555}}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_MEASURE, 1'b1, {16'd0, 16'd0, 16'd8192, 16'd0,
                                                   16'd0, 16'd0, 16'h7fff}}, 1'b0, none_r});
    rows.push_back('{'{isbc_pkg::OP_MEASURE, 1'b1, {16'd0, 16'd0, 16'd5400, 16'd0,
                                                   16'd0, 16'd0, 16'd0}}, 1'b0, none_r});
    foreach (rows[k]) send_frame(rows[k].f, rows[k].typed, rows[k].r);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(isbc_pkg::CFG_ACCEL_SCALE, 32'd20084);
          write_reg(isbc_pkg::CFG_GYRO_SCALE, 32'd1023001);
        end
        1: begin
          write_reg(isbc_pkg::CFG_ACCEL_SCALE, 32'd0);
          write_reg(isbc_pkg::CFG_GYRO_SCALE, 32'hffffffff);
        end
        2: begin
          write_reg(isbc_pkg::CFG_ACCEL_SCALE, 32'hffffffff);
          write_reg(isbc_pkg::CFG_GYRO_SCALE, 32'd0);
        end
        3: begin
          write_reg(isbc_pkg::CFG_ACCEL_SCALE, $urandom);
          write_reg(isbc_pkg::CFG_GYRO_SCALE, $urandom);
        end
        default: begin
          write_reg(isbc_pkg::CFG_ACCEL_SCALE, 32'd20084 + $urandom_range(200) - 100);
          write_reg(isbc_pkg::CFG_GYRO_SCALE, 32'd1023001 + $urandom_range(2000) - 1000);
        end
      endcase
      while (n_items < 14 + (ph + 1) * 265) begin
        if (n_items > 530) begin send_idle = 73; recv_idle = 18; end
        if (n_items > 1060) begin send_idle = 0; recv_idle = 0; end
        if (n_items >= 700 && !pressed) begin
          pressure_go = 1;
          pressed = 1;
        end
        if ($urandom_range(99) < 60) begin
          nburst = $urandom_range(1, 8);
          repeat (nburst)
            send_frame(level_frame(isbc_pkg::OP_SAMPLE, $urandom_range(9) != 0),
                       1'b0, none_r);
          send_frame(level_frame(isbc_pkg::OP_FINISH, 1'($urandom)), 1'b0, none_r);
          repeat ($urandom_range(1, 3))
            send_frame(level_frame(isbc_pkg::OP_MEASURE, $urandom_range(9) != 0),
                       1'b0, none_r);
        end else begin
          fr.op = isbc_pkg::op_t'($urandom_range(3));
          fr.ok = 1'($urandom);
          for (int i = 0; i < 7; i++) fr.raw[i] = pick_raw();
          send_frame(fr, 1'b0, none_r);
        end
      end
    end

    in_valid <= 1'b0;
    wait (expected_q.size() == 0);
    repeat (60) @(posedge clk);
    $display("Covered %0d frames, %0d result words, %0d calibrations, %0d in-band gravity",
             n_items, n_words, n_cal, n_grav);
    $display("Six scale settings incl. zero and full scale, idle mixes and a long stall");
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// ===== sim.f =====
hw/rtl/isbc_pkg.sv
hw/rtl/isbc_sdiv.sv
hw/rtl/isbc_lane.sv
hw/rtl/isbc_merge.sv
hw/rtl/imu_scale_bias_calibrate_core.sv
test/tb_imu_scale_bias_calibrate_core.sv
